FILE: hdl/kbs_pkg.sv
// kbs_pkg: shared types, widths and helpers for the spline segment evaluator.
// No dependencies; referenced by every module of the block but kbs_div.

package kbs_pkg;

	// default number of steps per segment
	localparam int STEPS_DEF = 20;

	// field widths
	localparam int PW   = 12;   // control point coordinate
	localparam int CFGW = 16;   // tension, bias, continuity
	localparam int IDXW = 2;    // register index
	localparam int OUTW = 18;   // curve coordinate, 1/16 pixel

	// basis arithmetic
	localparam int FW   = 18;   // one Q1.14 factor, 16384 +/- register
	localparam int SBW  = 2 * FW;    // product of two factors
	localparam int AQW  = 3 * FW;    // product of three factors
	localparam int QRW  = 26;   // basis scalar in Q20
	localparam int CW   = 28;   // cubic coefficient in Q20
	localparam int PRW  = PW + 1 + CW;  // point times coefficient
	localparam int AW   = 44;   // weighted sum over four points
	localparam int DW   = 58;   // forward difference, full scale
	localparam int DSH  = 16;   // power-of-two part of the divisor
	localparam int NW   = DW - DSH;  // dividend width of the divider
	localparam int QW   = 44;   // integer part of running values

	localparam int UNIT_Q14 = 16384;
	localparam logic signed [CW-1:0] ONE_Q20 = CW'(1 << 20);
	localparam logic signed [CW-1:0] TWO_Q20 = CW'(2 << 20);
	localparam logic signed [CW-1:0] THR_Q20 = CW'(3 << 20);
	localparam logic signed [QW-1:0] OUT_HI  = QW'(131071);
	localparam logic signed [QW-1:0] OUT_LO  = QW'(-131072);

	// register indexes
	localparam logic [IDXW-1:0] CFG_TENSION    = 2'd0;
	localparam logic [IDXW-1:0] CFG_BIAS       = 2'd1;
	localparam logic [IDXW-1:0] CFG_CONTINUITY = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_QMUL,
		ST_QRND,
		ST_CSET,
		ST_ACC,
		ST_DIFF,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_LOAD,
		ST_EMIT
	} kbs_state_t;

	// controller to datapath
	typedef struct packed {
		logic            take_point;
		logic            prod;
		logic            qmul;
		logic            qrnd;
		logic            cset;
		logic            acc;
		logic            acc_first;
		logic [1:0]      acc_idx;
		logic            diff;
		logic            div_start;
		logic            div_store;
		logic [1:0]      div_sel;
		logic            emit_init;
		logic            emit_step;
		logic            emit_last;
	} kbs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic window_full;
		logic div_done;
		logic out_free;
	} kbs_sts_t;

	// round a three-factor product to Q20, ties up
	function automatic logic signed [QRW-1:0] round_q20(input logic signed [AQW-1:0] a);
		logic signed [AQW-1:0] t;
		t = a + AQW'(1 << 22);
		return $signed(t[QRW+22:23]);
	endfunction

	// clamp to the output range
	function automatic logic signed [OUTW-1:0] sat_out(input logic signed [QW-1:0] v);
		logic signed [QW-1:0] c;
		c = v;
		if (v > OUT_HI)
			c = OUT_HI;
		if (v < OUT_LO)
			c = OUT_LO;
		return $signed(c[OUTW-1:0]);
	endfunction

endpackage

FILE: hdl/kbs_div.sv
// kbs_div: divider by a constant: reciprocal multiply in halves, one correction.
// Signed dividend over a constant positive divisor, floor semantics. Depends on nothing.

module kbs_div #(
	parameter int NUMW    = 42,
	parameter int DIVISOR = 8000,
	parameter int MW      = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [NUMW-1:0] num,
	output logic                   done,
	output logic signed [NUMW-1:0] quo,
	output logic [MW-1:0]          rem
);

	// dividend and reciprocal split in halves for a narrow multiplier
	localparam int HW   = (NUMW + 1) / 2;
	localparam int RCW  = NUMW + 1;
	localparam int OPW0 = ((RCW - HW) > HW) ? (RCW - HW) : HW;
	localparam int OPW  = (MW > OPW0) ? MW : OPW0;
	localparam int PPW  = 2 * OPW;
	localparam int PROW = NUMW + RCW;
	localparam logic [RCW-1:0] RECIP = RCW'((longint'(1) <<< NUMW) / longint'(DIVISOR));
	localparam logic [OPW-1:0] DIV_M = OPW'(DIVISOR);
	localparam logic [MW:0]    DIV_V = (MW + 1)'(DIVISOR);

	// phases: four partial products, two for quotient times divisor, correction
	localparam logic [2:0] PH_LL  = 3'd0;
	localparam logic [2:0] PH_LH  = 3'd1;
	localparam logic [2:0] PH_HL  = 3'd2;
	localparam logic [2:0] PH_HH  = 3'd3;
	localparam logic [2:0] PH_QL  = 3'd4;
	localparam logic [2:0] PH_QH  = 3'd5;
	localparam logic [2:0] PH_FIX = 3'd6;

	logic              busy_q;
	logic              done_q;
	logic [2:0]        ph_q;
	logic              neg_q;
	logic [NUMW-1:0]   mag_q;
	logic [PROW-1:0]   acc_q;
	logic [NUMW-1:0]   qm_q;
	logic [NUMW-1:0]   quo_q;
	logic [MW-1:0]     rem_q;
	logic [OPW-1:0]    op_a_c;
	logic [OPW-1:0]    op_b_c;
	logic [PPW-1:0]    pp_c;
	logic [NUMW-1:0]   qt_c;
	logic [NUMW-1:0]   rt_c;
	logic [MW:0]       r1_c;
	logic              ge_c;
	logic signed [NUMW-1:0] quo_s;

	// operand select, shared multiplier, remainder estimate
	always_comb begin
		qt_c   = acc_q[NUMW +: NUMW];
		op_a_c = '0;
		op_b_c = '0;
		unique case (ph_q)
			PH_LL: begin
				op_a_c = OPW'(mag_q[HW-1:0]);
				op_b_c = OPW'(RECIP[HW-1:0]);
			end
			PH_LH: begin
				op_a_c = OPW'(mag_q[HW-1:0]);
				op_b_c = OPW'(RECIP[RCW-1:HW]);
			end
			PH_HL: begin
				op_a_c = OPW'(mag_q[NUMW-1:HW]);
				op_b_c = OPW'(RECIP[HW-1:0]);
			end
			PH_HH: begin
				op_a_c = OPW'(mag_q[NUMW-1:HW]);
				op_b_c = OPW'(RECIP[RCW-1:HW]);
			end
			PH_QL: begin
				op_a_c = OPW'(qt_c[HW-1:0]);
				op_b_c = DIV_M;
			end
			PH_QH: begin
				op_a_c = OPW'(qt_c[NUMW-1:HW]);
				op_b_c = DIV_M;
			end
			default: ;
		endcase
		pp_c = op_a_c * op_b_c;
		rt_c = mag_q - qm_q;
		r1_c = rt_c[MW:0];
		ge_c = (r1_c >= DIV_V);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= PH_LL;
		end else begin
			done_q <= busy_q && (ph_q == PH_FIX);
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= PH_LL;
			end else if (busy_q) begin
				if (ph_q == PH_FIX)
					busy_q <= 1'b0;
				else
					ph_q <= ph_q + 3'd1;
			end
		end
	end

	// estimate from the reciprocal is low by at most one
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUMW-1];
			mag_q <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
		end else if (busy_q) begin
			unique case (ph_q)
				PH_LL:        acc_q <= PROW'(pp_c);
				PH_LH, PH_HL: acc_q <= acc_q + (PROW'(pp_c) << HW);
				PH_HH:        acc_q <= acc_q + (PROW'(pp_c) << (2 * HW));
				PH_QL:        qm_q  <= NUMW'(pp_c);
				PH_QH:        qm_q  <= qm_q + (NUMW'(pp_c) << HW);
				PH_FIX: begin
					quo_q <= qt_c + NUMW'(ge_c);
					rem_q <= ge_c ? MW'(r1_c - DIV_V) : r1_c[MW-1:0];
				end
				default: ;
			endcase
		end
	end

	// floor correction for a negative dividend
	always_comb begin
		quo_s = $signed(quo_q);
		quo   = quo_s;
		rem   = rem_q;
		if (neg_q) begin
			if (rem_q != '0) begin
				quo = -quo_s - NUMW'(1);
				rem = MW'(DIV_V) - rem_q;
			end else begin
				quo = -quo_s;
			end
		end
	end

	assign done = done_q;

endmodule

FILE: hdl/kbs_ctrl.sv
// kbs_ctrl: sequencer for one segment: basis, sums, divisions, emission.
// Depends on kbs_pkg for the state type and the command/status words.

module kbs_ctrl #(
	parameter int STEPS = kbs_pkg::STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output kbs_pkg::kbs_cmd_t  cmd,
	input  kbs_pkg::kbs_sts_t  sts
);

	import kbs_pkg::*;

	localparam int KW = $clog2(STEPS + 1);

	kbs_state_t      state_q;
	kbs_state_t      state_d;
	logic [1:0]      acc_cnt_q;
	logic [1:0]      div_cnt_q;
	logic [KW-1:0]   k_q;
	logic            last_k;

	assign last_k = (k_q == KW'(STEPS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.window_full)
					state_d = ST_PROD;
			end
			ST_PROD:  state_d = ST_QMUL;
			ST_QMUL:  state_d = ST_QRND;
			ST_QRND:  state_d = ST_CSET;
			ST_CSET:  state_d = ST_ACC;
			ST_ACC: begin
				if (acc_cnt_q == 2'd3)
					state_d = ST_DIFF;
			end
			ST_DIFF:   state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done)
					state_d = (div_cnt_q == 2'd2) ? ST_LOAD : ST_DIV_GO;
			end
			ST_LOAD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free && last_k)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd           = '0;
		cmd.acc_idx   = acc_cnt_q;
		cmd.acc_first = (acc_cnt_q == 2'd0);
		cmd.div_sel   = div_cnt_q;
		cmd.emit_last = last_k;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall       = 1'b0;
				cmd.take_point = in_valid;
			end
			ST_PROD:     cmd.prod      = 1'b1;
			ST_QMUL:     cmd.qmul      = 1'b1;
			ST_QRND:     cmd.qrnd      = 1'b1;
			ST_CSET:     cmd.cset      = 1'b1;
			ST_ACC:      cmd.acc       = 1'b1;
			ST_DIFF:     cmd.diff      = 1'b1;
			ST_DIV_GO:   cmd.div_start = 1'b1;
			ST_DIV_WAIT: cmd.div_store = sts.div_done;
			ST_LOAD:     cmd.emit_init = 1'b1;
			ST_EMIT:     cmd.emit_step = sts.out_free;
			default: ;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			acc_cnt_q <= '0;
			div_cnt_q <= '0;
			k_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC)
				acc_cnt_q <= acc_cnt_q + 2'd1;
			else
				acc_cnt_q <= '0;
			if (state_q == ST_IDLE)
				div_cnt_q <= '0;
			else if (state_q == ST_DIV_WAIT && sts.div_done)
				div_cnt_q <= div_cnt_q + 2'd1;
			if (state_q == ST_IDLE)
				k_q <= '0;
			else if (state_q == ST_EMIT && sts.out_free)
				k_q <= k_q + KW'(1);
		end
	end

endmodule

FILE: hdl/kbs_dp.sv
// kbs_dp: point window, basis and cubic sums, per-axis dividers, forward
// differencing and the output register. Depends on kbs_pkg and kbs_div.

module kbs_dp #(
	parameter int STEPS = kbs_pkg::STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kbs_pkg::kbs_cmd_t                cmd,
	output kbs_pkg::kbs_sts_t                sts,
	input  logic                             cfg_wr_en,
	input  logic [kbs_pkg::IDXW-1:0]         cfg_index,
	input  logic [kbs_pkg::CFGW-1:0]         cfg_data,
	input  logic [kbs_pkg::PW-1:0]           point_x,
	input  logic [kbs_pkg::PW-1:0]           point_y,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [kbs_pkg::OUTW-1:0]  curve_x,
	output logic signed [kbs_pkg::OUTW-1:0]  curve_y,
	output logic                             last_of_segment
);

	import kbs_pkg::*;

	// divisor 2^16 * STEPS^3, split into the power-of-two shift and STEPS^3
	localparam int M   = STEPS * STEPS * STEPS;
	localparam int MW  = $clog2(M + 1);
	localparam int RW  = MW + DSH;
	localparam logic [MW-1:0] M_W   = MW'(M);
	localparam logic [RW:0]   DEN_W = (RW + 1)'({M_W, 16'h0000});
	localparam logic [RW-1:0] HALF_W = RW'({M_W, 15'h0000});
	localparam logic signed [7:0]  N_S  = 8'(STEPS);
	localparam logic signed [12:0] N2_S = 13'(STEPS * STEPS);

	// configuration
	logic signed [CFGW-1:0] tension_q, bias_q, cont_q;

	// window: [axis][age], plus the oldest point of the current segment
	logic [PW-1:0] win_q [2][3];
	logic [PW-1:0] p0_q  [2];
	logic [1:0]    seen_q;
	logic [PW-1:0] fresh [2];

	// basis
	logic signed [FW-1:0]  s_c, bp_c, bm_c, cp_c, cm_c;
	logic signed [FW-1:0]  cp_q, cm_q;
	logic signed [SBW-1:0] sbp_q, sbm_q;
	logic signed [AQW-1:0] a_q [4];
	logic signed [QRW-1:0] q_q [4];
	logic signed [CW-1:0]  e1, e2, e3, e4;
	logic signed [CW-1:0]  coef_q [4][3];

	// sums and differences
	logic [PW-1:0]         pt_c  [2];
	logic signed [PRW-1:0] prod_c [2][3];
	logic signed [AW-1:0]  acc_q [2][3];
	logic signed [DW-1:0]  d_q   [2][3];

	// dividers
	logic                  div_done_c [2];
	logic signed [NW-1:0]  div_quo_c  [2];
	logic [MW-1:0]         div_rem_c  [2];

	// running values as integer part and remainder
	logic signed [QW-1:0]  dq_q [2][3];
	logic [RW-1:0]         dr_q [2][3];
	logic signed [QW-1:0]  vq_q [2];
	logic [RW-1:0]         vr_q [2];
	logic signed [QW-1:0]  bq_c [2][3];
	logic [RW-1:0]         br_c [2][3];
	logic [RW:0]           rs_c [2][3];
	logic                  ge_c [2][3];
	logic signed [QW-1:0]  sq_c [2][3];
	logic [RW-1:0]         sr_c [2][3];

	logic out_valid_q;
	logic last_q;
	logic signed [OUTW-1:0] cx_q, cy_q;

	assign fresh[0] = point_x;
	assign fresh[1] = point_y;

	// registers and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= '0;
			bias_q    <= '0;
			cont_q    <= '0;
			seen_q    <= '0;
			for (int ax = 0; ax < 2; ax++)
				for (int i = 0; i < 3; i++)
					win_q[ax][i] <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_TENSION:    tension_q <= $signed(cfg_data);
					CFG_BIAS:       bias_q    <= $signed(cfg_data);
					CFG_CONTINUITY: cont_q    <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (cmd.take_point) begin
				if (seen_q != 2'd3)
					seen_q <= seen_q + 2'd1;
				for (int ax = 0; ax < 2; ax++) begin
					win_q[ax][0] <= win_q[ax][1];
					win_q[ax][1] <= win_q[ax][2];
					win_q[ax][2] <= fresh[ax];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_point)
			for (int ax = 0; ax < 2; ax++)
				p0_q[ax] <= win_q[ax][0];
	end

	// basis factors
	always_comb begin
		s_c  = FW'(UNIT_Q14) - FW'(tension_q);
		bp_c = FW'(UNIT_Q14) + FW'(bias_q);
		bm_c = FW'(UNIT_Q14) - FW'(bias_q);
		cp_c = FW'(UNIT_Q14) + FW'(cont_q);
		cm_c = FW'(UNIT_Q14) - FW'(cont_q);
		e1 = CW'(q_q[0]);
		e2 = CW'(q_q[1]);
		e3 = CW'(q_q[2]);
		e4 = CW'(q_q[3]);
	end

	// basis products, rounding, coefficients
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			sbp_q <= s_c * bp_c;
			sbm_q <= s_c * bm_c;
			cp_q  <= cp_c;
			cm_q  <= cm_c;
		end
		if (cmd.qmul) begin
			a_q[0] <= sbp_q * cm_q;
			a_q[1] <= sbm_q * cp_q;
			a_q[2] <= sbp_q * cp_q;
			a_q[3] <= sbm_q * cm_q;
		end
		if (cmd.qrnd)
			for (int i = 0; i < 4; i++)
				q_q[i] <= round_q20(a_q[i]);
		if (cmd.cset) begin
			coef_q[0][0] <= -e1;
			coef_q[0][1] <= e1 + e1;
			coef_q[0][2] <= -e1;
			coef_q[1][0] <= e1 - e2 - e3 + TWO_Q20;
			coef_q[1][1] <= e3 - e1 - e1 + e2 + e2 - THR_Q20;
			coef_q[1][2] <= e1 - e2;
			coef_q[2][0] <= e2 + e3 - e4 - TWO_Q20;
			coef_q[2][1] <= e4 - e3 - e2 - e2 + THR_Q20;
			coef_q[2][2] <= e2;
			coef_q[3][0] <= e4;
			coef_q[3][1] <= -e4;
			coef_q[3][2] <= '0;
		end
	end

	// one point per cycle into the cubic sums
	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			unique case (cmd.acc_idx)
				2'd0: pt_c[ax] = p0_q[ax];
				2'd1: pt_c[ax] = win_q[ax][0];
				2'd2: pt_c[ax] = win_q[ax][1];
				2'd3: pt_c[ax] = win_q[ax][2];
				default: pt_c[ax] = '0;
			endcase
			for (int j = 0; j < 3; j++)
				prod_c[ax][j] = $signed({1'b0, pt_c[ax]}) * coef_q[cmd.acc_idx][j];
		end
	end

	// sums, then initial forward differences
	always_ff @(posedge clk) begin
		if (cmd.acc)
			for (int ax = 0; ax < 2; ax++)
				for (int j = 0; j < 3; j++)
					acc_q[ax][j] <= (cmd.acc_first ? '0 : acc_q[ax][j])
						+ AW'(prod_c[ax][j]);
		if (cmd.diff)
			for (int ax = 0; ax < 2; ax++) begin
				d_q[ax][0] <= DW'(acc_q[ax][0]) + DW'(acc_q[ax][1]) * N_S
					+ DW'(acc_q[ax][2]) * N2_S;
				d_q[ax][1] <= (DW'(acc_q[ax][0]) <<< 2) + (DW'(acc_q[ax][0]) <<< 1)
					+ ((DW'(acc_q[ax][1]) * N_S) <<< 1);
				d_q[ax][2] <= (DW'(acc_q[ax][0]) <<< 2) + (DW'(acc_q[ax][0]) <<< 1);
			end
	end

	// split each difference into whole steps and remainder
	for (genvar ax = 0; ax < 2; ax++) begin : g_div
		kbs_div #(
			.NUMW    (NW),
			.DIVISOR (M),
			.MW      (MW)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (cmd.div_start),
			.num    ($signed(d_q[ax][cmd.div_sel][DW-1:DSH])),
			.done   (div_done_c[ax]),
			.quo    (div_quo_c[ax]),
			.rem    (div_rem_c[ax])
		);
	end

	// forward difference step with carry from the remainder
	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			bq_c[ax][0] = vq_q[ax];
			br_c[ax][0] = vr_q[ax];
			bq_c[ax][1] = dq_q[ax][0];
			br_c[ax][1] = dr_q[ax][0];
			bq_c[ax][2] = dq_q[ax][1];
			br_c[ax][2] = dr_q[ax][1];
			for (int j = 0; j < 3; j++) begin
				rs_c[ax][j] = {1'b0, br_c[ax][j]} + {1'b0, dr_q[ax][j]};
				ge_c[ax][j] = (rs_c[ax][j] >= DEN_W);
				sr_c[ax][j] = ge_c[ax][j] ? RW'(rs_c[ax][j] - DEN_W) : RW'(rs_c[ax][j]);
				sq_c[ax][j] = bq_c[ax][j] + dq_q[ax][j]
					+ $signed({{(QW - 1){1'b0}}, ge_c[ax][j]});
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ax = 0; ax < 2; ax++) begin
			if (cmd.div_store) begin
				dq_q[ax][cmd.div_sel] <= QW'(div_quo_c[ax]);
				dr_q[ax][cmd.div_sel] <= {div_rem_c[ax], d_q[ax][cmd.div_sel][DSH-1:0]};
			end else if (cmd.emit_step) begin
				dq_q[ax][0] <= sq_c[ax][1];
				dr_q[ax][0] <= sr_c[ax][1];
				dq_q[ax][1] <= sq_c[ax][2];
				dr_q[ax][1] <= sr_c[ax][2];
			end
			if (cmd.emit_init) begin
				vq_q[ax] <= QW'({win_q[ax][0], 4'h0});
				vr_q[ax] <= HALF_W;
			end else if (cmd.emit_step) begin
				vq_q[ax] <= sq_c[ax][0];
				vr_q[ax] <= sr_c[ax][0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_step)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			cx_q   <= sat_out(vq_q[0]);
			cy_q   <= sat_out(vq_q[1]);
			last_q <= cmd.emit_last;
		end
	end

	always_comb begin
		sts.window_full = (seen_q == 2'd3);
		sts.div_done    = div_done_c[0] & div_done_c[1];
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid       = out_valid_q;
	assign curve_x         = cx_q;
	assign curve_y         = cy_q;
	assign last_of_segment = last_q;

endmodule

FILE: hdl/kb_spline_segment_evaluator.sv
// kb_spline_segment_evaluator: Kochanek-Bartels segment evaluator, top level.
// Depends on kbs_pkg, kbs_ctrl, kbs_dp (and kbs_div beneath it).
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one control point per word,
//    in whole pixels. The first three points only fill the window; each later
//    point closes a four-point window and starts one segment.
//  - Output channel (out_valid/out_stall) delivers STEPS+1 curve points per
//    segment in 1/16 pixel, saturated; last_of_segment marks the final one.
//  - Configuration: tension, bias, continuity (Q1.14) through cfg_wr_en,
//    cfg_index, cfg_data; write only while the block is idle.
//  - Sequence per segment after the point is taken: basis products, an
//    accumulation over the four points, the differences, then three constant
//    divisions, one after the other; then one curve point per cycle while the
//    receiver does not stall. A filling point only enters the window.
//  - in_stall is high from a segment's start until its last curve point sits
//    in the output register; the next point is taken while that word waits.
//  - A stalled receiver holds the output word and pauses emission.
//  - Reset clears the window, the point count, the registers and out_valid.

module kb_spline_segment_evaluator #(
	parameter int STEPS = kbs_pkg::STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [kbs_pkg::IDXW-1:0]         cfg_index,
	input  logic [kbs_pkg::CFGW-1:0]         cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [kbs_pkg::PW-1:0]           point_x,
	input  logic [kbs_pkg::PW-1:0]           point_y,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [kbs_pkg::OUTW-1:0]  curve_x,
	output logic signed [kbs_pkg::OUTW-1:0]  curve_y,
	output logic                             last_of_segment
);

	import kbs_pkg::*;

	kbs_cmd_t cmd;
	kbs_sts_t sts;

	// sequencer
	kbs_ctrl #(
		.STEPS (STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic and storage
	kbs_dp #(
		.STEPS (STEPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.point_x         (point_x),
		.point_y         (point_y),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.curve_x         (curve_x),
		.curve_y         (curve_y),
		.last_of_segment (last_of_segment)
	);

endmodule

FILE: hdl/kbs_chk.sv
// kbs_chk: port-level checks on the segment evaluator, bound to the top level.
// Depends on kbs_pkg for widths.

module kbs_chk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [kbs_pkg::IDXW-1:0]         cfg_index,
	input  logic [kbs_pkg::CFGW-1:0]         cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [kbs_pkg::PW-1:0]           point_x,
	input  logic [kbs_pkg::PW-1:0]           point_y,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic signed [kbs_pkg::OUTW-1:0]  curve_x,
	input  logic signed [kbs_pkg::OUTW-1:0]  curve_y,
	input  logic                             last_of_segment
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(curve_x)
			&& $stable(curve_y) && $stable(last_of_segment))
		else $error("output word changed under stall");

	// mid-segment words only while input is held off
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_segment |-> in_stall)
		else $error("input open while a segment is still being emitted");

	// a fresh point never yields a word in the next cycle
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid && !in_stall |=> !out_valid)
		else $error("output appeared one cycle after a point was taken");

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(point_x) && $stable(point_y))
		else $error("input word changed under stall");

	// register writes only while the block is idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> !in_stall && !out_valid && !$isunknown({cfg_index, cfg_data}))
		else $error("register written while a segment is in flight");

endmodule

bind kb_spline_segment_evaluator kbs_chk u_chk (.*);
